@@ design/wbps_pkg.sv @@
// package for the wildcard byte pattern search unit
// register indexes, field widths and parameter defaults; no dependencies
`default_nettype none

package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W    = 8;
	localparam int PATTERN_W = 64;
	localparam int CARE_W    = 16;
	localparam int LEN_W     = 5;
	localparam int OFFSET_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_CARE_MASK      = 2'd2,
		REG_PATTERN_LENGTH = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ design/wildcard_byte_pattern_search_unit.sv @@
// top level of the wildcard byte pattern search unit
// input register, masked window compare and result register; uses wbps_pkg
`default_nettype none

// Scans a region one byte per word and reports the first place where the
// newest pattern_length bytes match the configured pattern, with clear care
// bits acting as wildcards. One byte is taken every cycle while the result
// side keeps up; a byte is held in the input register and its result, if
// any, is loaded into the output register as the byte leaves it. The compare
// of all pattern lengths against the shifted window is the one combinational
// step between the two registers. A result is either found=1 with the start
// offset, or found=0 on the region's last byte; after a match the rest of the
// region gives no result. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
module wildcard_byte_pattern_search_unit #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wbps_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [wbps_pkg::BYTE_W-1:0]    s_axis_tdata,   // data_byte
	input  wire logic                           s_axis_tlast,   // last
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [wbps_pkg::OFFSET_W-1:0]       m_axis_tdata,   // match_offset
	output logic                                m_axis_tuser    // found
);

	localparam int BW = wbps_pkg::BYTE_W;

	logic [wbps_pkg::PATTERN_W-1:0] pattern_low_q;
	logic [wbps_pkg::PATTERN_W-1:0] pattern_high_q;
	logic [wbps_pkg::CARE_W-1:0]    care_mask_q;
	logic [wbps_pkg::LEN_W-1:0]     pattern_length_q;

	logic          in_valid_s1;
	logic [BW-1:0] in_byte_s1;
	logic          in_last_s1;

	logic [BW-1:0]          window_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   reported_q;

	logic                          out_valid_q;
	logic                          out_found_q;
	logic [wbps_pkg::OFFSET_W-1:0] out_offset_q;

	logic                                advance;
	logic                                fire;
	logic [wbps_pkg::LEN_W-1:0]          len_eff;
	logic [BW-1:0]                       win_next [MAX_PATTERN];
	logic [2*wbps_pkg::PATTERN_W-1:0]    pat_all;
	logic [MAX_PATTERN-1:0]              len_hit;
	logic                                hit_sel;
	logic [OFFSET_BITS-1:0]              seen_next;
	logic [OFFSET_BITS-1:0]              offset_full;
	logic                                match;
	logic                                emit;

	// handshake
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = out_offset_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= wbps_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			unique case (wbps_pkg::cfg_reg_t'(cfg_index))
				wbps_pkg::REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				wbps_pkg::REG_CARE_MASK:      care_mask_q      <= cfg_data[wbps_pkg::CARE_W-1:0];
				wbps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[wbps_pkg::LEN_W-1:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_last_s1 <= s_axis_tlast;
		end
	end

	// masked compare over the shifted window
	assign pat_all = {pattern_high_q, pattern_low_q};
	assign len_eff = (pattern_length_q > wbps_pkg::LEN_W'(MAX_PATTERN)) ?
		wbps_pkg::LEN_W'(MAX_PATTERN) : pattern_length_q;

	always_comb begin
		win_next[0] = in_byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_next[k] = window_q[k-1];
		end
	end

	// one hit bit per candidate length
	always_comb begin
		for (int l = 0; l < MAX_PATTERN; l++) begin
			len_hit[l] = 1'b1;
			for (int j = 0; j <= l; j++) begin
				if (care_mask_q[j] && (win_next[l-j] != pat_all[BW*j +: BW])) begin
					len_hit[l] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit_sel = 1'b0;
		for (int l = 0; l < MAX_PATTERN; l++) begin
			if (len_eff == wbps_pkg::LEN_W'(l + 1)) begin
				hit_sel = len_hit[l];
			end
		end
	end

	assign seen_next   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
	assign offset_full = seen_next - OFFSET_BITS'(len_eff);
	assign match       = !reported_q && hit_sel && (seen_next >= OFFSET_BITS'(len_eff));
	assign emit        = !reported_q && (match || in_last_s1);

	// region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= '0;
			end
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (fire) begin
			if (in_last_s1) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= '0;
				end
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= win_next[k];
				end
				seen_q <= seen_next;
				if (match) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_offset_q <= '0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
			if (fire && emit) begin
				out_found_q  <= match;
				out_offset_q <= match ? wbps_pkg::OFFSET_W'(offset_full) : '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/wbps_checker.sv @@
// port-level checks for the wildcard byte pattern search unit
// bound to wildcard_byte_pattern_search_unit; uses wbps_pkg widths
`default_nettype none

module wbps_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [wbps_pkg::OFFSET_W-1:0] m_axis_tdata,
	input wire logic                          m_axis_tuser
);

	// a no-match result carries a zero offset
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("no-match result with nonzero offset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

	// an empty output side never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

	// nothing comes out without a word having gone in
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_axis_tvalid) && $past(arst_n)) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a preceding input word");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/wildcard_byte_pattern_search_unit_tb.sv @@
// testbench for the wildcard byte pattern search unit: directed and random byte regions
// with random gaps and stalls, each result checked against a local scan predictor
// depends on wbps_pkg and wildcard_byte_pattern_search_unit
`timescale 1ns / 100ps

module wildcard_byte_pattern_search_unit_tb;
	import wbps_pkg::*;

	localparam int WINDOW_DEPTH   = MAX_PATTERN_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1550;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} scan_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	cfg_reg_t            cfg_index = REG_PATTERN_LOW;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [BYTE_W-1:0]   s_axis_tdata = '0;  // data_byte
	logic                s_axis_tlast = 1'b0; // last
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OFFSET_W-1:0] m_axis_tdata;        // match_offset
	logic                m_axis_tuser;        // found

	// predictor copy of configuration and region state
	logic [2*PATTERN_W-1:0] cfg_pat = '0;
	logic [CARE_W-1:0]      cfg_care = '0;
	logic [LEN_W-1:0]       cfg_len = LEN_W'(1);
	logic [BYTE_W-1:0]      win [WINDOW_DEPTH];
	logic [OFFSET_W-1:0]    seen = '0;
	bit                     reported = 1'b0;

	scan_result_t      pending_results[$];
	logic [BYTE_W-1:0] region_buf[$];
	int                mismatches = 0;
	int                sent_items = 0;
	int                stalled_cycles = 0;
	bit                idle_on = 1'b1;
	bit                narrow = 1'b0;

	wildcard_byte_pattern_search_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	initial begin
		foreach (win[k]) win[k] = '0;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50) return 0;
		if (r < 86) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] noise_byte();
		if (narrow) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return BYTE_W'($urandom);
	endfunction

	function automatic void scan_predict(input logic [BYTE_W-1:0] b, input logic l);
		int           len;
		bit           hit;
		scan_result_t res;
		len = (cfg_len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_len);
		if (!reported) begin
			for (int k = WINDOW_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
			win[0] = b;
			if (seen != '1) seen = seen + 1'b1;
			hit = (len != 0) && (seen >= OFFSET_W'(len));
			for (int j = 0; j < len; j++) begin
				if (cfg_care[j] && win[len-1-j] != cfg_pat[8*j +: 8]) hit = 1'b0;
			end
			if (hit) begin
				res.found = 1'b1;
				res.offset = seen - OFFSET_W'(len);
				pending_results = {pending_results, res};
				reported = 1'b1;
			end else if (l) begin
				res = '0;
				pending_results = {pending_results, res};
			end
		end
		if (l) begin
			foreach (win[k]) win[k] = '0;
			seen = '0;
			reported = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		scan_predict(b, l);
		sent_items++;
	endtask

	task automatic send_region();
		foreach (region_buf[i]) send_byte(region_buf[i], i == region_buf.size() - 1);
	endtask

	task automatic drain_scan();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// writes all four registers, upper data bits carry junk that must be ignored
	task automatic load_pattern(input logic [PATTERN_W-1:0] lo, input logic [PATTERN_W-1:0] hi,
			input logic [CARE_W-1:0] care, input logic [LEN_W-1:0] len);
		drain_scan();
		cfg_we    <= 1'b1;
		cfg_index <= REG_PATTERN_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_CARE_MASK;
		cfg_data  <= {32'($urandom), 16'($urandom), care};
		@(posedge clk);
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data  <= {32'($urandom), 27'($urandom), len};
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg_pat  = {hi, lo};
		cfg_care = care;
		cfg_len  = len;
	endtask

	task automatic test_reset_values();
		region_buf = '{8'h5A, 8'h00, 8'hFF};
		send_region();
		region_buf = '{8'h00};
		send_region();
	endtask

	task automatic test_exact_match();
		load_pattern(64'h0000_0000_0180_FF00, '0, 16'hFFFF, LEN_W'(4));
		region_buf = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01};
		send_region();
		region_buf = '{8'h00, 8'hFF};
		send_region();
	endtask

	task automatic test_wildcards();
		load_pattern(64'h0000_0000_0180_FF00, '0, 16'h0009, LEN_W'(4));
		region_buf = '{8'h00, 8'h12, 8'h34, 8'h01, 8'h77, 8'h55};
		send_region();
	endtask

	task automatic test_zero_length();
		load_pattern('0, '0, '0, LEN_W'(0));
		region_buf = '{8'h00, 8'hFF};
		send_region();
	endtask

	task automatic test_oversized_length();
		load_pattern('1, '1, '0, LEN_W'(31));
		region_buf = '{8'hFF, 8'hFF, 8'hFF};
		send_region();
	endtask

	task automatic build_region();
		int plen;
		int lead;
		int tail;
		int pos;
		region_buf.delete();
		plen = (cfg_len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_len);
		lead = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
		tail = $urandom_range(0, 6);
		for (int i = 0; i < lead; i++) region_buf = {region_buf, noise_byte()};
		if (plen != 0 && $urandom_range(0, 9) < 7) begin
			for (int j = 0; j < plen; j++)
				region_buf = {region_buf, (cfg_care[j] ? cfg_pat[8*j +: 8] : noise_byte())};
			if ($urandom_range(0, 4) == 0) begin
				pos = lead + $urandom_range(0, plen - 1);
				region_buf[pos] = region_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < tail; i++) region_buf = {region_buf, noise_byte()};
		if (region_buf.size() == 0) region_buf = {region_buf, noise_byte()};
	endtask

	task automatic test_random_regions();
		logic [PATTERN_W-1:0] lo;
		logic [PATTERN_W-1:0] hi;
		logic [CARE_W-1:0]    care;
		logic [LEN_W-1:0]     len;
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			narrow = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < 8; j++) begin
				lo[8*j +: 8] = noise_byte();
				hi[8*j +: 8] = noise_byte();
			end
			case ($urandom_range(0, 9))
				0: len = LEN_W'(16);
				1: len = LEN_W'(1);
				2: len = LEN_W'(0);
				3: len = LEN_W'($urandom_range(17, 31));
				4, 5, 6: len = LEN_W'($urandom_range(1, 6));
				default: len = LEN_W'($urandom_range(7, 16));
			endcase
			case ($urandom_range(0, 5))
				0: care = '0;
				1: care = '1;
				default: care = CARE_W'($urandom);
			endcase
			load_pattern(lo, hi, care, len);
			idle_on = ($urandom_range(0, 4) != 0);
			repeat ($urandom_range(3, 12)) begin
				build_region();
				send_region();
			end
		end
		idle_on = 1'b1;
	endtask

	// sink side: ready stretches broken by stalls of random length
	initial begin : sink_side
		int span;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			span = pick_idle();
			if (span > 0) begin
				m_axis_tready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word found=%0b offset=%0d",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.found)
					report_mismatch($sformatf("found %0b, want %0b", m_axis_tuser, want.found));
				if (m_axis_tdata !== want.offset)
					report_mismatch($sformatf("offset %0d, want %0d", m_axis_tdata, want.offset));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_exact_match();
		test_wildcards();
		test_zero_length();
		test_oversized_length();
		test_random_regions();
		drain_scan();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
